// ===== rtl/tfsm_pkg.sv =====
package tfsm_pkg;

	// Controller states
	typedef enum logic [2:0] {
		MODE_IDLE     = 3'd0,
		MODE_NORMAL   = 3'd1,
		MODE_WARNING  = 3'd2,
		MODE_CRITICAL = 3'd3,
		MODE_EMERG    = 3'd4,
		MODE_SHUTDOWN = 3'd5
	} mode_t;

	// Classified events
	typedef enum logic [2:0] {
		EV_NORMAL   = 3'd0,
		EV_WARNING  = 3'd1,
		EV_CRITICAL = 3'd2,
		EV_EXTREME  = 3'd3,
		EV_SUCCESS  = 3'd4,
		EV_FAILURE  = 3'd5,
		EV_INIT     = 3'd6
	} event_t;

	// Input action codes
	localparam logic [1:0] ACT_SAMPLE  = 2'd0;
	localparam logic [1:0] ACT_SUCCESS = 2'd1;
	localparam logic [1:0] ACT_FAILURE = 2'd2;
	localparam logic [1:0] ACT_INIT    = 2'd3;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_WARN_THR = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CRIT_THR = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_EXTR_THR = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LOW_DUTY = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MED_DUTY = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_HIGH_DUTY = 3'd5;

	// Reset values of the configuration registers
	localparam logic [7:0] WARN_THR_RST  = 8'd70;
	localparam logic [7:0] CRIT_THR_RST  = 8'd85;
	localparam logic [7:0] EXTR_THR_RST  = 8'd95;
	localparam logic [6:0] LOW_DUTY_RST  = 7'd30;
	localparam logic [6:0] MED_DUTY_RST  = 7'd60;
	localparam logic [6:0] HIGH_DUTY_RST = 7'd85;

	localparam logic [6:0] DUTY_FULL = 7'd100;
	localparam logic [6:0] DUTY_OFF  = 7'd0;

	// Severity codes
	localparam logic [1:0] SEV_INFO  = 2'd0;
	localparam logic [1:0] SEV_WARN  = 2'd1;
	localparam logic [1:0] SEV_ERROR = 2'd2;
	localparam logic [1:0] SEV_CRIT  = 2'd3;

	typedef struct packed {
		logic [7:0] warn;
		logic [7:0] crit;
		logic [7:0] extr;
	} thresholds_t;

	typedef struct packed {
		logic [6:0] low;
		logic [6:0] med;
		logic [6:0] high;
	} duties_t;

	// One result item, in output field order
	typedef struct packed {
		logic [31:0] event_total;
		logic [31:0] transition_total;
		logic [1:0]  severity;
		logic        emergency_on;
		logic [6:0]  fan_duty;
		logic        changed;
		mode_t       prior_mode;
		mode_t       mode;
	} result_t;

	// Fixed transition table
	function automatic mode_t next_mode(mode_t cur, event_t ev);
		mode_t nxt;
		nxt = cur;
		case (cur)
			MODE_IDLE: begin
				if (ev == EV_NORMAL || ev == EV_INIT) nxt = MODE_NORMAL;
			end
			MODE_NORMAL: begin
				case (ev)
					EV_WARNING:  nxt = MODE_WARNING;
					EV_CRITICAL: nxt = MODE_CRITICAL;
					EV_EXTREME:  nxt = MODE_EMERG;
					default:     nxt = MODE_NORMAL;
				endcase
			end
			MODE_WARNING: begin
				case (ev)
					EV_NORMAL:   nxt = MODE_NORMAL;
					EV_CRITICAL: nxt = MODE_CRITICAL;
					EV_EXTREME:  nxt = MODE_EMERG;
					EV_SUCCESS:  nxt = MODE_NORMAL;
					default:     nxt = MODE_WARNING;
				endcase
			end
			MODE_CRITICAL: begin
				case (ev)
					EV_NORMAL:   nxt = MODE_NORMAL;
					EV_WARNING:  nxt = MODE_WARNING;
					EV_EXTREME:  nxt = MODE_EMERG;
					EV_SUCCESS:  nxt = MODE_WARNING;
					default:     nxt = MODE_CRITICAL;
				endcase
			end
			MODE_EMERG: begin
				case (ev)
					EV_NORMAL:   nxt = MODE_NORMAL;
					EV_WARNING:  nxt = MODE_WARNING;
					EV_SUCCESS:  nxt = MODE_WARNING;
					EV_FAILURE:  nxt = MODE_SHUTDOWN;
					default:     nxt = MODE_EMERG;
				endcase
			end
			MODE_SHUTDOWN: begin
				if (ev == EV_INIT) nxt = MODE_IDLE;
			end
			default: nxt = MODE_IDLE;
		endcase
		return nxt;
	endfunction

	function automatic logic [1:0] severity_of(mode_t m);
		logic [1:0] sev;
		case (m)
			MODE_WARNING:  sev = SEV_WARN;
			MODE_CRITICAL: sev = SEV_ERROR;
			MODE_EMERG:    sev = SEV_CRIT;
			MODE_SHUTDOWN: sev = SEV_CRIT;
			default:       sev = SEV_INFO;
		endcase
		return sev;
	endfunction

	function automatic logic [6:0] sat_duty(logic [6:0] d);
		return (d > DUTY_FULL) ? DUTY_FULL : d;
	endfunction

endpackage

// ===== rtl/tfsm_front.sv =====
module tfsm_front (
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [15:0]           s_tdata,   // [7:0] temperature, [15:8] zero
	input  logic [7:0]            s_tuser,   // [1:0] action, [7:2] zero
	input  tfsm_pkg::thresholds_t thr,
	input  logic                  q_full,
	output logic                  q_push,
	output tfsm_pkg::event_t      q_event
);
	import tfsm_pkg::*;

	logic [7:0] temp;
	logic [1:0] action;

	assign temp   = s_tdata[7:0];
	assign action = s_tuser[1:0];

	assign s_tready = !q_full;
	assign q_push   = s_tvalid && !q_full;

	// Classify: extreme test first, then critical, then warning
	always_comb begin
		case (action)
			ACT_SAMPLE: begin
				if (temp >= thr.extr)      q_event = EV_EXTREME;
				else if (temp >= thr.crit) q_event = EV_CRITICAL;
				else if (temp >= thr.warn) q_event = EV_WARNING;
				else                       q_event = EV_NORMAL;
			end
			ACT_SUCCESS: q_event = EV_SUCCESS;
			ACT_FAILURE: q_event = EV_FAILURE;
			ACT_INIT:    q_event = EV_INIT;
			default:     q_event = EV_INIT;
		endcase
	end

endmodule

// ===== rtl/tfsm_queue.sv =====
module tfsm_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  tfsm_pkg::event_t push_event,
	input  logic             pop,
	output logic             full,
	output logic             not_empty,
	output tfsm_pkg::event_t head_event
);
	import tfsm_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	event_t             mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push;
	logic               do_pop;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign not_empty  = (count_q != '0);
	assign head_event = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && not_empty;

	// Storage
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_event;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop)      count_q <= count_q + 1'b1;
			else if (!do_push && do_pop) count_q <= count_q - 1'b1;
		end
	end

endmodule

// ===== rtl/tfsm_back.sv =====
module tfsm_back (
	input  logic              clk,
	input  logic              arst_n,
	input  tfsm_pkg::duties_t duty_cfg,
	input  logic              q_not_empty,
	input  tfsm_pkg::event_t  q_event,
	output logic              q_pop,
	output logic              m_tvalid,
	input  logic              m_tready,
	output tfsm_pkg::result_t m_result
);
	import tfsm_pkg::*;

	mode_t       mode_q;
	mode_t       prior_q;
	logic [6:0]  duty_q;
	logic        emerg_q;
	logic [31:0] trans_q;
	logic [31:0] events_q;
	logic        out_valid_q;
	result_t     out_q;

	mode_t       nxt;
	logic        chg;
	mode_t       mode_n;
	mode_t       prior_n;
	logic [6:0]  duty_n;
	logic        emerg_n;
	logic [31:0] trans_n;
	logic [31:0] events_n;

	// Pop when the output register is free or being drained
	assign q_pop = q_not_empty && (!out_valid_q || m_tready);

	// Next-state and entry actions
	always_comb begin
		nxt      = next_mode(mode_q, q_event);
		chg      = (nxt != mode_q);
		mode_n   = mode_q;
		prior_n  = prior_q;
		duty_n   = duty_q;
		emerg_n  = emerg_q;
		trans_n  = trans_q;
		events_n = events_q + 32'd1;
		if (chg) begin
			mode_n  = nxt;
			prior_n = mode_q;
			trans_n = trans_q + 32'd1;
			emerg_n = (nxt == MODE_EMERG);
			case (nxt)
				MODE_NORMAL:   duty_n = sat_duty(duty_cfg.low);
				MODE_WARNING:  duty_n = sat_duty(duty_cfg.med);
				MODE_CRITICAL: duty_n = sat_duty(duty_cfg.high);
				MODE_EMERG:    duty_n = DUTY_FULL;
				MODE_SHUTDOWN: duty_n = DUTY_FULL;
				default:       duty_n = DUTY_OFF;
			endcase
		end
	end

	// Controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			prior_q  <= MODE_IDLE;
			duty_q   <= DUTY_OFF;
			emerg_q  <= 1'b0;
			trans_q  <= '0;
			events_q <= '0;
		end else if (q_pop) begin
			mode_q   <= mode_n;
			prior_q  <= prior_n;
			duty_q   <= duty_n;
			emerg_q  <= emerg_n;
			trans_q  <= trans_n;
			events_q <= events_n;
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (q_pop) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (q_pop) begin
			out_q.mode             <= mode_n;
			out_q.prior_mode       <= prior_n;
			out_q.changed          <= chg;
			out_q.fan_duty         <= duty_n;
			out_q.emergency_on     <= emerg_n;
			out_q.severity         <= severity_of(mode_n);
			out_q.transition_total <= trans_n;
			out_q.event_total      <= events_n;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_result = out_q;

endmodule

// ===== rtl/thermal_fan_state_machine.sv =====
// Thermal fan controller: six-state machine on temperature samples and events.
// Path: an input transaction is classified into the queue, then the table lookup
// goes into the output register; both steps are registered.
// Throughput: one transaction per cycle while the output is not stalled.
// Reset: arst_n clears state, counters and queue, and loads the configuration
// defaults; no clearing pass, the block is ready as soon as reset is released.
module thermal_fan_state_machine #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [7:0] temperature, [15:8] zero
	input  logic [7:0]  s_tuser,   // [1:0] action, [7:2] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	// [2:0] mode, [5:3] prior_mode, [6] changed, [13:7] fan_duty,
	// [14] emergency_on, [16:15] severity, [48:17] transition_total,
	// [80:49] event_total, [87:81] zero
	output logic [87:0] m_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [tfsm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]  cfg_data
);
	import tfsm_pkg::*;

	thresholds_t thr_q;
	duties_t     duty_q;
	logic        q_push;
	logic        q_pop;
	logic        q_full;
	logic        q_not_empty;
	event_t      push_event;
	event_t      head_event;
	result_t     result;

	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q.warn  <= WARN_THR_RST;
			thr_q.crit  <= CRIT_THR_RST;
			thr_q.extr  <= EXTR_THR_RST;
			duty_q.low  <= LOW_DUTY_RST;
			duty_q.med  <= MED_DUTY_RST;
			duty_q.high <= HIGH_DUTY_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_WARN_THR:  thr_q.warn  <= cfg_data;
				CFG_CRIT_THR:  thr_q.crit  <= cfg_data;
				CFG_EXTR_THR:  thr_q.extr  <= cfg_data;
				CFG_LOW_DUTY:  duty_q.low  <= cfg_data[6:0];
				CFG_MED_DUTY:  duty_q.med  <= cfg_data[6:0];
				CFG_HIGH_DUTY: duty_q.high <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	tfsm_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.thr      (thr_q),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_event  (push_event)
	);

	tfsm_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_event (push_event),
		.pop        (q_pop),
		.full       (q_full),
		.not_empty  (q_not_empty),
		.head_event (head_event)
	);

	tfsm_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.duty_cfg    (duty_q),
		.q_not_empty (q_not_empty),
		.q_event     (head_event),
		.q_pop       (q_pop),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_result    (result)
	);

	assign m_tdata = {7'd0, result};

endmodule

// ===== rtl/tfsm_checker.sv =====
module tfsm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [87:0] m_tdata
);
	import tfsm_pkg::*;

	// A stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// A transition always leaves a different state than it enters
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[6] |-> m_tdata[2:0] != m_tdata[5:3])
		else $error("transition reported with equal mode and prior mode");

	// Emergency flag tracks the emergency state
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[14] == (m_tdata[2:0] == MODE_EMERG))
		else $error("emergency flag disagrees with mode");

	// Latched duty is saturated
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[13:7] <= DUTY_FULL)
		else $error("fan duty above full scale");

endmodule

bind thermal_fan_state_machine tfsm_checker u_tfsm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
